// File: hdl/wgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wgs_pkg
// shared types, constants and helpers for the window geometry slew unit
// ----------------------------------------------------------------------------
package wgs_pkg;

    localparam int NUM_WINDOWS   = 8;
    localparam int COORD_BITS    = 12;
    localparam int IDX_BITS      = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;

    localparam int WIN_BITS      = 3;
    localparam int FIELD_BITS    = 12;
    localparam int CFG_BITS      = 12;
    localparam int CFG_IDX_BITS  = 2;

    localparam int VAL_BITS      = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;
    localparam int WORK_BITS     = VAL_BITS + 3;

    localparam int IN_FIELD_BITS  = WIN_BITS + 4 * FIELD_BITS;
    localparam int S_TDATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = WIN_BITS + 8 * FIELD_BITS + 1;
    localparam int M_TDATA_BITS   = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int RESET_FRAME_W = 640;
    localparam int RESET_FRAME_H = 480;
    localparam int RESET_STEP    = 20;
    localparam int LAYOUT_OFFSET = 4;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SET  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_W = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_H = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTH  = 2'd3;

    typedef logic [COORD_BITS-1:0]       coord_t;
    typedef logic signed [WORK_BITS-1:0] work_t;
    typedef logic [FIELD_BITS-1:0]       field_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic slew;
        logic clamp;
        logic left;
        logic right;
        logic draw;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic tick_smooth;
        logic changed;
        logic out_free;
    } status_t;

    function automatic coord_t sat_coord(input int v);
        coord_t r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > COORD_MAX)
        begin
            r = coord_t'(COORD_MAX);
        end
        else
        begin
            r = coord_t'(v);
        end
        return r;
    endfunction

    function automatic work_t sat_work(input work_t v);
        work_t r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > work_t'(COORD_MAX))
        begin
            r = work_t'(COORD_MAX);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic work_t slew_value(input work_t cur, input work_t goal,
                                         input work_t step);
        work_t d;
        d = goal - cur;
        if (d > step)
        begin
            d = step;
        end
        else if (d < -step)
        begin
            d = -step;
        end
        return cur + d;
    endfunction

    function automatic coord_t reset_goal_x(input int n);
        return (n == 0) ? '0 : sat_coord(RESET_FRAME_W / 2);
    endfunction

    function automatic coord_t reset_goal_y(input int n);
        return (n == 0) ? '0 : sat_coord(RESET_FRAME_H / 2);
    endfunction

    function automatic coord_t reset_goal_w(input int n);
        return sat_coord(RESET_FRAME_W - LAYOUT_OFFSET * n);
    endfunction

    function automatic coord_t reset_goal_h(input int n);
        return sat_coord(RESET_FRAME_H - LAYOUT_OFFSET * n);
    endfunction

endpackage
`default_nettype wire

// File: hdl/wgs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wgs_ctrl
// sequencer: capture, table read, slew, frame bounding, draw and result issue
// ----------------------------------------------------------------------------
module wgs_ctrl
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    input  wgs_pkg::status_t status,
    output wgs_pkg::cmd_t    cmd
);
    import wgs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_SLEW  = 3'd2;
    localparam logic [2:0] ST_CLAMP = 3'd3;
    localparam logic [2:0] ST_LEFT  = 3'd4;
    localparam logic [2:0] ST_RIGHT = 3'd5;
    localparam logic [2:0] ST_DRAW  = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = s_axis_tvalid;
                if (s_axis_tvalid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.load   = 1'b1;
                state_next = status.tick_smooth ? ST_SLEW : ST_DRAW;
            end
            ST_SLEW:
            begin
                cmd.slew   = 1'b1;
                state_next = status.changed ? ST_CLAMP : ST_DRAW;
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_LEFT;
            end
            ST_LEFT:
            begin
                cmd.left   = 1'b1;
                state_next = ST_RIGHT;
            end
            ST_RIGHT:
            begin
                cmd.right  = 1'b1;
                state_next = ST_DRAW;
            end
            ST_DRAW:
            begin
                cmd.draw   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

endmodule
`default_nettype wire

// File: hdl/wgs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wgs_datapath
// window table, configuration registers, working registers and result register
// ----------------------------------------------------------------------------
module wgs_datapath
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wgs_pkg::cmd_t                       cmd,
    output wgs_pkg::status_t                    status,
    input  wire  [wgs_pkg::S_TDATA_BITS-1:0]    s_axis_tdata,
    input  wire                                 s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [wgs_pkg::M_TDATA_BITS-1:0]    m_axis_tdata,
    input  wire                                 cfg_valid,
    input  wire  [wgs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire  [wgs_pkg::CFG_BITS-1:0]        cfg_data
);
    import wgs_pkg::*;

    // configuration
    logic [CFG_BITS-1:0] frame_w_reg;
    logic [CFG_BITS-1:0] frame_h_reg;
    logic [CFG_BITS-1:0] step_reg;
    logic                smooth_reg;

    // captured transaction
    logic                act_reg;
    logic [WIN_BITS-1:0] win_reg;
    coord_t              nx_reg;
    coord_t              ny_reg;
    coord_t              nw_reg;
    coord_t              nh_reg;

    // window table
    coord_t cur_x_reg  [NUM_WINDOWS];
    coord_t cur_y_reg  [NUM_WINDOWS];
    coord_t cur_w_reg  [NUM_WINDOWS];
    coord_t cur_h_reg  [NUM_WINDOWS];
    coord_t goal_x_reg [NUM_WINDOWS];
    coord_t goal_y_reg [NUM_WINDOWS];
    coord_t goal_w_reg [NUM_WINDOWS];
    coord_t goal_h_reg [NUM_WINDOWS];

    // working registers
    work_t  wx_reg;
    work_t  wy_reg;
    work_t  ww_reg;
    work_t  wh_reg;
    coord_t gx_reg;
    coord_t gy_reg;
    coord_t gw_reg;
    coord_t gh_reg;
    logic   moved_reg;
    work_t  dx_reg;
    work_t  dy_reg;

    logic                    out_valid_reg;
    logic [M_TDATA_BITS-1:0] out_data_reg;

    logic [IDX_BITS-1:0] idx;
    logic                in_range;
    work_t               fw;
    work_t               fh;
    work_t               step;
    work_t               right_w;
    work_t               right_h;
    work_t               draw_dx;
    work_t               draw_dy;
    work_t               clip_w;
    work_t               clip_h;
    logic [M_TDATA_BITS-1:0] result;

    assign idx      = IDX_BITS'(win_reg);
    assign in_range = (int'(win_reg) < NUM_WINDOWS);
    assign fw       = work_t'(frame_w_reg);
    assign fh       = work_t'(frame_h_reg);
    assign step     = work_t'(step_reg);

    assign status.tick_smooth = (act_reg == ACT_TICK) && smooth_reg && in_range;
    assign status.changed     = (wx_reg != work_t'(gx_reg)) || (wy_reg != work_t'(gy_reg))
                             || (ww_reg != work_t'(gw_reg)) || (wh_reg != work_t'(gh_reg));
    assign status.out_free    = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w_reg <= CFG_BITS'(RESET_FRAME_W);
            frame_h_reg <= CFG_BITS'(RESET_FRAME_H);
            step_reg    <= CFG_BITS'(RESET_STEP);
            smooth_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_W: frame_w_reg <= cfg_data;
                REG_FRAME_H: frame_h_reg <= cfg_data;
                REG_STEP:    step_reg    <= cfg_data;
                REG_SMOOTH:  smooth_reg  <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= s_axis_tuser;
            win_reg <= s_axis_tdata[WIN_BITS-1:0];
            nx_reg  <= sat_coord(int'(s_axis_tdata[WIN_BITS +: FIELD_BITS]));
            ny_reg  <= sat_coord(int'(s_axis_tdata[WIN_BITS + FIELD_BITS +: FIELD_BITS]));
            nw_reg  <= sat_coord(int'(s_axis_tdata[WIN_BITS + 2*FIELD_BITS +: FIELD_BITS]));
            nh_reg  <= sat_coord(int'(s_axis_tdata[WIN_BITS + 3*FIELD_BITS +: FIELD_BITS]));
        end
    end

    // table loads the reset layout on reset; written back once per in-range transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NUM_WINDOWS; n++)
            begin
                cur_x_reg[n]  <= '0;
                cur_y_reg[n]  <= '0;
                cur_w_reg[n]  <= sat_coord(RESET_FRAME_W);
                cur_h_reg[n]  <= sat_coord(RESET_FRAME_H);
                goal_x_reg[n] <= reset_goal_x(n);
                goal_y_reg[n] <= reset_goal_y(n);
                goal_w_reg[n] <= reset_goal_w(n);
                goal_h_reg[n] <= reset_goal_h(n);
            end
        end
        else if (cmd.draw && in_range)
        begin
            cur_x_reg[idx]  <= COORD_BITS'(wx_reg);
            cur_y_reg[idx]  <= COORD_BITS'(wy_reg);
            cur_w_reg[idx]  <= COORD_BITS'(ww_reg);
            cur_h_reg[idx]  <= COORD_BITS'(wh_reg);
            goal_x_reg[idx] <= gx_reg;
            goal_y_reg[idx] <= gy_reg;
            goal_w_reg[idx] <= gw_reg;
            goal_h_reg[idx] <= gh_reg;
        end
    end

    always_comb
    begin
        right_w = ((wx_reg + (ww_reg >>> 1)) > fw) ? (fw - wx_reg - work_t'(1)) <<< 1 : ww_reg;
        right_h = ((wy_reg + (wh_reg >>> 1)) > fh) ? (fh - wy_reg - work_t'(1)) <<< 1 : wh_reg;
        draw_dx = wx_reg - (ww_reg - (ww_reg >>> 1));
        draw_dy = wy_reg - (wh_reg - (wh_reg >>> 1));
        clip_w  = ((dx_reg + ww_reg) > fw) ? sat_work(fw - dx_reg) : ww_reg;
        clip_h  = ((dy_reg + wh_reg) > fh) ? sat_work(fh - dy_reg) : wh_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            moved_reg <= 1'b0;
            if (act_reg == ACT_SET)
            begin
                gx_reg <= nx_reg;
                gy_reg <= ny_reg;
                gw_reg <= nw_reg;
                gh_reg <= nh_reg;
                wx_reg <= smooth_reg ? work_t'(cur_x_reg[idx]) : work_t'(nx_reg);
                wy_reg <= smooth_reg ? work_t'(cur_y_reg[idx]) : work_t'(ny_reg);
                ww_reg <= smooth_reg ? work_t'(cur_w_reg[idx]) : work_t'(nw_reg);
                wh_reg <= smooth_reg ? work_t'(cur_h_reg[idx]) : work_t'(nh_reg);
            end
            else
            begin
                gx_reg <= goal_x_reg[idx];
                gy_reg <= goal_y_reg[idx];
                gw_reg <= goal_w_reg[idx];
                gh_reg <= goal_h_reg[idx];
                wx_reg <= work_t'(cur_x_reg[idx]);
                wy_reg <= work_t'(cur_y_reg[idx]);
                ww_reg <= work_t'(cur_w_reg[idx]);
                wh_reg <= work_t'(cur_h_reg[idx]);
            end
        end
        else if (cmd.slew)
        begin
            moved_reg <= status.changed;
            wx_reg    <= slew_value(wx_reg, work_t'(gx_reg), step);
            wy_reg    <= slew_value(wy_reg, work_t'(gy_reg), step);
            ww_reg    <= slew_value(ww_reg, work_t'(gw_reg), step);
            wh_reg    <= slew_value(wh_reg, work_t'(gh_reg), step);
        end
        else if (cmd.clamp)
        begin
            wx_reg <= (wx_reg > fw) ? fw : wx_reg;
            wy_reg <= (wy_reg > fh) ? fh : wy_reg;
            ww_reg <= (ww_reg > fw) ? fw : ww_reg;
            wh_reg <= (wh_reg > fh) ? fh : wh_reg;
        end
        else if (cmd.left)
        begin
            if ((wx_reg - (ww_reg >>> 1)) < 0)
            begin
                ww_reg <= wx_reg <<< 1;
            end
            if ((wy_reg - (wh_reg >>> 1)) < 0)
            begin
                wh_reg <= wy_reg <<< 1;
            end
        end
        else if (cmd.right)
        begin
            ww_reg <= sat_work(right_w);
            wh_reg <= sat_work(right_h);
        end
        else if (cmd.draw)
        begin
            dx_reg <= (draw_dx < 0) ? '0 : draw_dx;
            dy_reg <= (draw_dy < 0) ? '0 : draw_dy;
        end
    end

    always_comb
    begin
        result = '0;
        result[0 +: WIN_BITS] = win_reg;
        if (in_range)
        begin
            result[WIN_BITS +: FIELD_BITS]                = FIELD_BITS'(wx_reg);
            result[WIN_BITS + FIELD_BITS +: FIELD_BITS]   = FIELD_BITS'(wy_reg);
            result[WIN_BITS + 2*FIELD_BITS +: FIELD_BITS] = FIELD_BITS'(ww_reg);
            result[WIN_BITS + 3*FIELD_BITS +: FIELD_BITS] = FIELD_BITS'(wh_reg);
            result[WIN_BITS + 4*FIELD_BITS]               = moved_reg;
            result[WIN_BITS + 4*FIELD_BITS + 1 +: FIELD_BITS] = FIELD_BITS'(sat_work(dx_reg));
            result[WIN_BITS + 5*FIELD_BITS + 1 +: FIELD_BITS] = FIELD_BITS'(sat_work(dy_reg));
            result[WIN_BITS + 6*FIELD_BITS + 1 +: FIELD_BITS] = FIELD_BITS'(clip_w);
            result[WIN_BITS + 7*FIELD_BITS + 1 +: FIELD_BITS] = FIELD_BITS'(clip_h);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire

// File: hdl/window_geometry_slew_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// window_geometry_slew_top
// per-window centre and size glide toward targets, bounded to the frame
//
// channel  direction  signals                                  width
// s_axis   in         tvalid tready tdata tuser                56 + 1
// m_axis   out        tvalid tready tdata                      104
// cfg      in         cfg_valid cfg_ready cfg_index cfg_data   2 + 12
//
// set-target and unsmoothed tick: controller passes read, draw and emit
// tick that finds the window at its target: read, slew, draw, emit
// tick that moves adds clamp, left and right before draw; one transaction at a time
// s_axis_tready is high while the controller is idle, even if a result waits
// reset loads the default frame, step and window layout; no clearing pass
// ----------------------------------------------------------------------------
module window_geometry_slew_top
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // window, new_x, new_y, new_w, new_h, zero pad
    input  wire  [wgs_pkg::S_TDATA_BITS-1:0]    s_axis_tdata,
    // action
    input  wire                                 s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // window_out, pos_x, pos_y, width_out, height_out, moved,
    // draw_x, draw_y, draw_w, draw_h, zero pad
    output logic [wgs_pkg::M_TDATA_BITS-1:0]    m_axis_tdata,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [wgs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire  [wgs_pkg::CFG_BITS-1:0]        cfg_data
);
    import wgs_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    wgs_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    wgs_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result issued over a waiting result");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("new transaction taken while busy");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a transaction in flight");

endmodule
`default_nettype wire
